// File: design/sgrf_pkg.sv
// ----------------------------------------------------------------------------
// sgrf_pkg
// Shared constants, types and helpers of the separator grid rectangle finder.
// ----------------------------------------------------------------------------
package sgrf_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned MAX_RECTS  = 64;

  localparam int unsigned PIX_W  = 32;
  localparam int unsigned CFG_W  = 9;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned SIZE_W = 9;

  localparam int unsigned XW         = $clog2(MAX_WIDTH);
  localparam int unsigned YW         = $clog2(MAX_HEIGHT);
  localparam int unsigned ADDR_W     = XW + YW;
  localparam int unsigned MASK_DEPTH = 2 ** ADDR_W;
  localparam int unsigned CNT_W      = $clog2(MAX_RECTS + 1);

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);

  localparam logic [CFG_W-1:0] MAX_W_C = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] MAX_H_C = CFG_W'(MAX_HEIGHT);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } size_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              sep;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  rect_x;
    logic [POS_W-1:0]  rect_y;
    logic [SIZE_W-1:0] rect_width;
    logic [SIZE_W-1:0] rect_height;
    logic              last_rect;
    logic              none_found;
    logic              rect_overflow;
  } result_t;

  function automatic logic [CFG_W-1:0] sat_size(logic [CFG_W-1:0] v, logic [CFG_W-1:0] lim);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: design/sgrf_ram.sv
// ----------------------------------------------------------------------------
// sgrf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgrf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/sgrf_front.sv
// ----------------------------------------------------------------------------
// sgrf_front
// Configuration registers and pixel intake: tracks the raster position,
// latches the separator color and classifies every pixel into a mask word.
// ----------------------------------------------------------------------------
module sgrf_front import sgrf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel_rgba_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output size_t            size_o,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_ready_i
);

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic [CFG_W-1:0] lx_q, lx_d;
  logic [CFG_W-1:0] ly_q, ly_d;
  logic [PIX_W-1:0] sep_color_q, sep_color_d;
  logic             accept;
  logic             first;
  logic             row_end;
  logic             col_end;
  logic [PIX_W-1:0] ref_color;

  assign size_o.width  = sat_size(width_q, MAX_W_C);
  assign size_o.height = sat_size(height_q, MAX_H_C);

  assign full        = !cmd_ready_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = push && cmd_ready_i;

  assign first     = (lx_q == '0) && (ly_q == '0);
  assign ref_color = first ? pixel_rgba_i : sep_color_q;
  assign row_end   = (lx_q == size_o.width - CFG_W'(1));
  assign col_end   = (ly_q == size_o.height - CFG_W'(1));

  assign cmd_valid_o = accept;
  assign cmd_o.addr  = {ly_q[YW-1:0], lx_q[XW-1:0]};
  assign cmd_o.sep   = (pixel_rgba_i == ref_color);
  assign cmd_o.last  = row_end && col_end;

  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    lx_d        = lx_q;
    ly_d        = ly_q;
    sep_color_d = sep_color_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_IMAGE_WIDTH: begin
          width_d = cfg_data_i;
          lx_d    = '0;
          ly_d    = '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_d = cfg_data_i;
          lx_d     = '0;
          ly_d     = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      sep_color_d = ref_color;
      if (row_end) begin
        lx_d = '0;
        ly_d = col_end ? '0 : ly_q + CFG_W'(1);
      end else begin
        lx_d = lx_q + CFG_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CFG_W'(1);
      height_q    <= CFG_W'(1);
      lx_q        <= '0;
      ly_q        <= '0;
      sep_color_q <= '0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      lx_q        <= lx_d;
      ly_q        <= ly_d;
      sep_color_q <= sep_color_d;
    end
  end

endmodule

// File: design/sgrf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sgrf_cmd_fifo
// Short queue of classified mask words between the front and the scanner.
// ----------------------------------------------------------------------------
module sgrf_cmd_fifo import sgrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wvalid_i,
  input  cmd_t wdata_i,
  output logic wready_o,
  output logic rvalid_o,
  output cmd_t rdata_o,
  input  logic rready_i
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wptr_q, wptr_d;
  logic [CMD_PTR_W-1:0] rptr_q, rptr_d;
  logic [CMD_PTR_W:0]   cnt_q, cnt_d;
  logic                 do_w;
  logic                 do_r;

  assign wready_o = (cnt_q != (CMD_PTR_W + 1)'(CMD_DEPTH));
  assign rvalid_o = (cnt_q != '0);
  assign rdata_o  = mem_q[rptr_q];
  assign do_w     = wvalid_i && wready_o;
  assign do_r     = rready_i && rvalid_o;

  always_comb begin
    wptr_d = do_w ? wptr_q + CMD_PTR_W'(1) : wptr_q;
    rptr_d = do_r ? rptr_q + CMD_PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_w && !do_r) begin
      cnt_d = cnt_q + (CMD_PTR_W + 1)'(1);
    end else if (do_r && !do_w) begin
      cnt_d = cnt_q - (CMD_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_w) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: design/sgrf_back.sv
// ----------------------------------------------------------------------------
// sgrf_back
// Writes mask words into the separator mask and, after the last pixel of an
// image, scans the mask and emits the rectangles through an output register.
// ----------------------------------------------------------------------------
module sgrf_back import sgrf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  size_t   size_i,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_ready_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    pop
);

  typedef enum logic [12:0] {
    ST_IDLE    = 13'h0001,
    ST_ROW_RD  = 13'h0002,
    ST_ROW_CK  = 13'h0004,
    ST_COL_RD  = 13'h0008,
    ST_COL_CK  = 13'h0010,
    ST_RUN_RD  = 13'h0020,
    ST_RUN_CK  = 13'h0040,
    ST_HGT_RD  = 13'h0080,
    ST_HGT_CK  = 13'h0100,
    ST_SKIP_RD = 13'h0200,
    ST_SKIP_CK = 13'h0400,
    ST_EMIT    = 13'h0800,
    ST_FIN     = 13'h1000
  } state_e;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] x_q, x_d;
  logic [CFG_W-1:0] y_q, y_d;
  logic [CFG_W-1:0] sx_q, sx_d;
  logic [CFG_W-1:0] sy_q, sy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             pend_v_q, pend_v_d;
  result_t          pend_q, pend_d;
  logic             out_v_q, out_v_d;
  result_t          out_q, out_d;

  logic [CFG_W-1:0]  rd_x;
  logic [CFG_W-1:0]  rd_y;
  logic [ADDR_W-1:0] rd_addr;
  logic [0:0]        mask_rd;
  logic              mask_bit;
  logic              can_push;
  logic              out_push;
  result_t           push_res;
  result_t           new_rect;
  logic [CFG_W-1:0]  w;
  logic [CFG_W-1:0]  h;

  assign w        = size_i.width;
  assign h        = size_i.height;
  assign rd_addr  = {rd_y[YW-1:0], rd_x[XW-1:0]};
  assign mask_bit = mask_rd[0];

  sgrf_ram #(
    .WIDTH(1),
    .DEPTH(MASK_DEPTH)
  ) u_mask (
    .clk_i  (clk_i),
    .we_i   (cmd_valid_i && cmd_ready_o),
    .waddr_i(cmd_i.addr),
    .wdata_i(cmd_i.sep),
    .raddr_i(rd_addr),
    .rdata_o(mask_rd)
  );

  assign can_push = !out_v_q || pop;

  always_comb begin
    new_rect               = '0;
    new_rect.rect_x        = sx_q[POS_W-1:0];
    new_rect.rect_y        = y_q[POS_W-1:0];
    new_rect.rect_width    = SIZE_W'(x_q - sx_q);
    new_rect.rect_height   = SIZE_W'(sy_q - y_q);
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    rd_x        = x_q;
    rd_y        = y_q;
    cmd_ready_o = 1'b0;
    out_push    = 1'b0;
    push_res    = pend_q;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i && cmd_i.last) begin
          y_d      = '0;
          cnt_d    = '0;
          ovf_d    = 1'b0;
          pend_v_d = 1'b0;
          state_d  = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        rd_x    = '0;
        state_d = (y_q >= h) ? ST_FIN : ST_ROW_CK;
      end
      ST_ROW_CK: begin
        if (mask_bit) begin
          y_d     = y_q + CFG_W'(1);
          state_d = ST_ROW_RD;
        end else begin
          x_d     = '0;
          state_d = ST_COL_RD;
        end
      end
      ST_COL_RD: begin
        if (x_q >= w) begin
          y_d     = y_q + CFG_W'(1);
          state_d = ST_SKIP_RD;
        end else begin
          state_d = ST_COL_CK;
        end
      end
      ST_COL_CK: begin
        if (!mask_bit) begin
          sx_d    = x_q;
          state_d = ST_RUN_RD;
        end else begin
          state_d = ST_COL_RD;
        end
        x_d = x_q + CFG_W'(1);
      end
      ST_RUN_RD: begin
        if (x_q >= w) begin
          sy_d    = y_q + CFG_W'(1);
          state_d = ST_HGT_RD;
        end else begin
          state_d = ST_RUN_CK;
        end
      end
      ST_RUN_CK: begin
        if (mask_bit) begin
          sy_d    = y_q + CFG_W'(1);
          state_d = ST_HGT_RD;
        end else begin
          x_d     = x_q + CFG_W'(1);
          state_d = ST_RUN_RD;
        end
      end
      ST_HGT_RD: begin
        rd_x    = sx_q;
        rd_y    = sy_q;
        state_d = (sy_q >= h) ? ST_EMIT : ST_HGT_CK;
      end
      ST_HGT_CK: begin
        if (mask_bit) begin
          state_d = ST_EMIT;
        end else begin
          sy_d    = sy_q + CFG_W'(1);
          state_d = ST_HGT_RD;
        end
      end
      ST_EMIT: begin
        if (cnt_q < CNT_W'(MAX_RECTS)) begin
          if (!pend_v_q || can_push) begin
            out_push = pend_v_q;
            pend_d   = new_rect;
            pend_v_d = 1'b1;
            cnt_d    = cnt_q + CNT_W'(1);
            state_d  = ST_COL_RD;
          end
        end else begin
          ovf_d   = 1'b1;
          state_d = ST_COL_RD;
        end
      end
      ST_SKIP_RD: begin
        rd_x    = '0;
        state_d = (y_q >= h) ? ST_FIN : ST_SKIP_CK;
      end
      ST_SKIP_CK: begin
        y_d     = y_q + CFG_W'(1);
        state_d = mask_bit ? ST_ROW_RD : ST_SKIP_RD;
      end
      ST_FIN: begin
        if (can_push) begin
          out_push = 1'b1;
          if (pend_v_q) begin
            push_res.last_rect     = 1'b1;
            push_res.rect_overflow = ovf_q;
          end else begin
            push_res            = '0;
            push_res.last_rect  = 1'b1;
            push_res.none_found = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_v_d = out_v_q && !pop;
    out_d   = out_q;
    if (out_push) begin
      out_v_d = 1'b1;
      out_d   = push_res;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      y_q      <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      y_q      <= y_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

endmodule

// File: design/separator_grid_rect_finder.sv
// ----------------------------------------------------------------------------
// separator_grid_rect_finder
// Loads an image as a one-bit separator mask and reports the rectangles of a
// separator grid, in scan order, through a result queue.
// ----------------------------------------------------------------------------
// Pixels enter one word per cycle while the scanner is idle; during a scan the
// four-word queue takes up to four pixels of the next image, then holds full.
// After the last pixel of an image the scan starts; every mask read of the scan
// passes a read state and a check state, and every rectangle an emit state.
// A stalled result queue holds the scan. Reset clears all control state and sets
// the size to 1 by 1; mask contents stay undefined until written.
module separator_grid_rect_finder import sgrf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [PIX_W-1:0]  pixel_rgba_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic              empty,
  input  logic              pop,
  output logic [POS_W-1:0]  rect_x_o,
  output logic [POS_W-1:0]  rect_y_o,
  output logic [SIZE_W-1:0] rect_width_o,
  output logic [SIZE_W-1:0] rect_height_o,
  output logic              last_rect_o,
  output logic              none_found_o,
  output logic              rect_overflow_o
);

  size_t   size;
  logic    f_valid;
  cmd_t    f_cmd;
  logic    f_ready;
  logic    q_valid;
  cmd_t    q_cmd;
  logic    q_ready;
  logic    res_valid;
  result_t res;

  sgrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .pixel_rgba_i(pixel_rgba_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .size_o      (size),
    .cmd_valid_o (f_valid),
    .cmd_o       (f_cmd),
    .cmd_ready_i (f_ready)
  );

  sgrf_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wvalid_i(f_valid),
    .wdata_i (f_cmd),
    .wready_o(f_ready),
    .rvalid_o(q_valid),
    .rdata_o (q_cmd),
    .rready_i(q_ready)
  );

  sgrf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_ready_o(q_ready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .pop        (pop)
  );

  assign empty           = !res_valid;
  assign rect_x_o        = res.rect_x;
  assign rect_y_o        = res.rect_y;
  assign rect_width_o    = res.rect_width;
  assign rect_height_o   = res.rect_height;
  assign last_rect_o     = res.last_rect;
  assign none_found_o    = res.none_found;
  assign rect_overflow_o = res.rect_overflow;

endmodule

// File: design/sgrf_checker.sv
// ----------------------------------------------------------------------------
// sgrf_checker
// Port-level checks on the result queue of the rectangle finder.
// ----------------------------------------------------------------------------
module sgrf_checker import sgrf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic [POS_W-1:0]  rect_x_o,
  input logic [POS_W-1:0]  rect_y_o,
  input logic [SIZE_W-1:0] rect_width_o,
  input logic [SIZE_W-1:0] rect_height_o,
  input logic              last_rect_o,
  input logic              none_found_o,
  input logic              rect_overflow_o
);

  // A waiting word stays until it is popped.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result word dropped before pop");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(rect_x_o) && $stable(rect_y_o) &&
      $stable(rect_width_o) && $stable(rect_height_o) && $stable(last_rect_o))
    else $error("result word changed while stalled");

  // The empty-image word is final, has no overflow flag and carries zero position and size.
  a_none_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && none_found_o |-> last_rect_o && !rect_overflow_o &&
      rect_width_o == '0 && rect_height_o == '0 && rect_x_o == '0 && rect_y_o == '0)
    else $error("malformed none-found word");

  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && rect_overflow_o |-> last_rect_o && !none_found_o)
    else $error("overflow flag on a word that is not final");

  a_rect_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !none_found_o |-> rect_width_o != '0 && rect_height_o != '0)
    else $error("rectangle of zero size reported");

endmodule

bind separator_grid_rect_finder sgrf_checker u_checker (.*);
